/* src/xee_pkg.sv */
// Shared types, constants and helper functions for the XML entity escaper.
`default_nettype none

package xee_pkg;

	localparam int LOOKAHEAD = 5;
	localparam int WIN_DEPTH = LOOKAHEAD + 1;

	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_QUOT = 8'h22;

	typedef enum logic [2:0] {
		K_PLAIN = 3'd0,
		K_LT    = 3'd1,
		K_GT    = 3'd2,
		K_AMP   = 3'd3,
		K_APOS  = 3'd4,
		K_QUOT  = 3'd5
	} xee_kind_t;

	typedef struct packed {
		xee_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} xee_item_t;

	typedef logic [LOOKAHEAD-1:0][7:0] xee_follow_t;

	// True when the bytes after an ampersand start one of the five entity tails.
	function automatic logic is_entity(input xee_follow_t f, input logic [2:0] avail);
		logic m_lt, m_gt, m_amp, m_apos, m_quot;
		m_lt   = (avail >= 3'd3) && f[0] == "l" && f[1] == "t" && f[2] == ";";
		m_gt   = (avail >= 3'd3) && f[0] == "g" && f[1] == "t" && f[2] == ";";
		m_amp  = (avail >= 3'd4) && f[0] == "a" && f[1] == "m" && f[2] == "p"
			&& f[3] == ";";
		m_apos = (avail >= 3'd5) && f[0] == "a" && f[1] == "p" && f[2] == "o"
			&& f[3] == "s" && f[4] == ";";
		m_quot = (avail >= 3'd5) && f[0] == "q" && f[1] == "u" && f[2] == "o"
			&& f[3] == "t" && f[4] == ";";
		return m_lt | m_gt | m_amp | m_apos | m_quot;
	endfunction

	function automatic xee_kind_t classify(input logic [7:0] b, input xee_follow_t f,
			input logic [2:0] avail);
		xee_kind_t k;
		unique case (b)
			CH_LT:   k = K_LT;
			CH_GT:   k = K_GT;
			CH_APOS: k = K_APOS;
			CH_QUOT: k = K_QUOT;
			CH_AMP:  k = is_entity(f, avail) ? K_PLAIN : K_AMP;
			default: k = K_PLAIN;
		endcase
		return k;
	endfunction

	function automatic logic [2:0] kind_len(input xee_kind_t k);
		logic [2:0] n;
		unique case (k) inside
			K_LT, K_GT:     n = 3'd4;
			K_AMP:          n = 3'd5;
			K_APOS, K_QUOT: n = 3'd6;
			default:        n = 3'd1;
		endcase
		return n;
	endfunction

	// Byte number idx of the expansion of one classified character.
	function automatic logic [7:0] kind_char(input xee_kind_t k, input logic [2:0] idx,
			input logic [7:0] data);
		logic [5:0][7:0] s;
		unique case (k)
			K_LT:    s = {"&lt;", 16'h0000};
			K_GT:    s = {"&gt;", 16'h0000};
			K_AMP:   s = {"&amp;", 8'h00};
			K_APOS:  s = "&apos;";
			K_QUOT:  s = "&quot;";
			default: s = {data, 40'h0};
		endcase
		return s[3'd5 - idx];
	endfunction

endpackage

`default_nettype wire

/* src/xee_front.sv */
// Front end: lookahead window that classifies each input character.
`default_nettype none

module xee_front
	import xee_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic      in_last,
	output logic           push,
	output xee_item_t      push_item,
	input  wire logic      q_full
);

	logic [7:0] win_q [WIN_DEPTH];
	logic [2:0] cnt_q;
	logic       flush_q;
	logic       accept, push_steady, push_flush;
	xee_follow_t follow_steady, follow_flush;

	always_comb begin
		for (int i = 0; i < LOOKAHEAD - 1; i++) begin
			follow_steady[i] = win_q[i+1];
		end
		follow_steady[LOOKAHEAD-1] = in_byte;
		for (int i = 0; i < LOOKAHEAD; i++) begin
			follow_flush[i] = win_q[i+1];
		end
	end

	assign in_ready = !flush_q && (cnt_q != 3'(LOOKAHEAD) || !q_full);
	assign accept = in_valid && in_ready;
	assign push_steady = accept && !in_last && cnt_q == 3'(LOOKAHEAD);
	assign push_flush = flush_q && cnt_q != 3'd0 && !q_full;
	assign push = push_steady || push_flush;

	always_comb begin
		if (flush_q) begin
			push_item.kind = classify(win_q[0], follow_flush, cnt_q - 3'd1);
			push_item.last = (cnt_q == 3'd1);
		end else begin
			push_item.kind = classify(win_q[0], follow_steady, 3'(LOOKAHEAD));
			push_item.last = 1'b0;
		end
		push_item.data = win_q[0];
	end

	// The window holds no reset; the count says which entries are live.
	always_ff @(posedge clk) begin
		if (push_flush || push_steady) begin
			for (int i = 0; i < LOOKAHEAD - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[LOOKAHEAD-1] <= push_steady ? in_byte : win_q[LOOKAHEAD];
		end else if (accept) begin
			win_q[cnt_q] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 3'd0;
			flush_q <= 1'b0;
		end else if (push_flush) begin
			cnt_q <= cnt_q - 3'd1;
			if (cnt_q == 3'd1) begin
				flush_q <= 1'b0;
			end
		end else if (accept && !push_steady) begin
			cnt_q <= cnt_q + 3'd1;
			if (in_last) begin
				flush_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/xee_fifo.sv */
// Small queue of classified characters between the front and back ends.
`default_nettype none

module xee_fifo
	import xee_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire xee_item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output xee_item_t      head,
	output logic           not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	xee_item_t      mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/xee_back.sv */
// Back end: expands each classified character into its output bytes.
`default_nettype none

module xee_back
	import xee_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire xee_item_t head,
	input  wire logic      q_valid,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [7:0]     out_byte,
	output logic           out_last
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       emit, at_end;

	assign emit   = q_valid && (!valid_q || out_ready);
	assign at_end = (idx_q == kind_len(head.kind) - 3'd1);
	assign pop    = emit && at_end;

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= kind_char(head.kind, idx_q, head.data);
			last_q <= head.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* src/xml_entity_escaper_top.sv */
// Top level of the streaming XML entity escaper.
`default_nettype none

// Streams a string one byte per beat and emits its XML-escaped form one byte per
// beat, with out_last on the final byte of each string. Each input character is
// held in a five-byte lookahead window until five later characters arrive or the
// string ends, so results lag the input by five characters; an input beat is
// taken every cycle while the window slides, unless the queue is full. After the
// beat with in_last the input stalls while the held characters drain into the
// queue. The output runs at one byte per cycle while out_ready is high, so a
// character that expands into an entity of up to six bytes holds the input back
// through the queue only when the expansions outpace it.

module xml_entity_escaper_top
	import xee_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	logic      push, q_full, pop, q_valid;
	xee_item_t push_item, head;

	xee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	xee_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.not_empty (q_valid)
	);

	xee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_valid   (q_valid),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire
